// ----- rtl/spa_pkg.sv -----
// Shared types, codes and defaults of the sparse polynomial add/sub unit.
package spa_pkg;

   localparam int MAX_TERMS_DEF = 32;
   localparam int TERM_COUNT_WIDTH = 7;

   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_RUN    = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] coefficient;
      logic [15:0]        exponent;
   } req_type;

   typedef struct packed {
      logic signed [32:0]          result_coefficient;
      logic [15:0]                 result_exponent;
      logic                        empty_res;
      logic                        overflowed;
      logic [TERM_COUNT_WIDTH-1:0] term_count;
      logic                        last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] coefficient;
      logic [15:0]        exponent;
   } term_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic run_start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic has_work;
      logic step_blocked;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/sparse_polynomial_add_sub_unit.sv -----
// Sparse polynomial add/subtract unit: top level.
// Load beats (kind 0 for A, 1 for B) are accepted back to back while idle and write
// the term into that operand's RAM; a load into a full store is dropped and flags
// overflowed on the next run. A run beat (kind 2) merges the stores by exponent: each
// merge step reads both term RAMs (FETCH), then compares and combines (COMPARE), and
// COMPARE can wait while a result stall holds the result register. One result term is
// held back so the final beat can carry last and term_count; an all-cancelled run
// gives a single beat with empty_res set. Inputs stall during a run. Both stores are
// empty again after the run; no clearing pass is needed after reset. subtract_mode
// (csr) selects A - B and is written by the user only while idle (not enforced).
module sparse_polynomial_add_sub_unit #(
   parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spa_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   spa_pkg::cmd_type cmd;
   spa_pkg::sts_type sts;

   spa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   spa_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/spa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/spa_datapath.sv -----
// Datapath: term stores, counts, merge pointers, pending term and result register.
module spa_datapath #(
   parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  spa_pkg::cmd_type cmd,
   output spa_pkg::sts_type sts,
   input  spa_pkg::req_type req_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spa_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int NW = $clog2(2 * MAX_TERMS + 1);
   localparam int TW = $bits(spa_pkg::term_type);

   logic              subtract_ff, subtract_in;
   logic [CW-1:0]     cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in;
   logic              dropped_ff, dropped_in;
   logic [NW-1:0]     n_ff, n_in;
   logic              pend_valid_ff, pend_valid_in;
   logic signed [32:0] pend_coef_ff, pend_coef_in;
   logic [15:0]       pend_exp_ff, pend_exp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   spa_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [TW-1:0]     rd_a_raw, rd_b_raw;
   spa_pkg::term_type ta, tb;
   spa_pkg::term_type wr_term;
   logic              wr_a, wr_b;
   logic              a_av, b_av;
   logic signed [32:0] a_ext, b_ext, b_signed, sum;
   logic signed [32:0] cand_coef;
   logic [15:0]       cand_exp;
   logic              cand_keep, adv_i, adv_j;
   logic              out_free, emit_step;

   assign wr_term.coefficient = req_data.coefficient;
   assign wr_term.exponent    = req_data.exponent;
   assign wr_a = cmd.load_a && (cnt_a_ff < CW'(MAX_TERMS));
   assign wr_b = cmd.load_b && (cnt_b_ff < CW'(MAX_TERMS));

   spa_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[AW-1:0]),
      .wr_data (wr_term),
      .rd_addr (i_ff[AW-1:0]),
      .rd_data (rd_a_raw)
   );

   spa_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[AW-1:0]),
      .wr_data (wr_term),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (rd_b_raw)
   );

   assign ta = spa_pkg::term_type'(rd_a_raw);
   assign tb = spa_pkg::term_type'(rd_b_raw);

   assign a_av     = i_ff < cnt_a_ff;
   assign b_av     = j_ff < cnt_b_ff;
   assign a_ext    = 33'(ta.coefficient);
   assign b_ext    = 33'(tb.coefficient);
   assign b_signed = subtract_ff ? -b_ext : b_ext;
   assign sum      = a_ext + b_signed;

   always_comb begin
      cand_coef = b_signed;
      cand_exp  = tb.exponent;
      cand_keep = 1'b1;
      adv_i     = 1'b0;
      adv_j     = 1'b1;
      if (a_av && b_av && (ta.exponent == tb.exponent)) begin
         cand_coef = sum;
         cand_exp  = ta.exponent;
         cand_keep = (sum != 33'sd0);
         adv_i     = 1'b1;
         adv_j     = 1'b1;
      end else if (a_av && (!b_av || (ta.exponent > tb.exponent))) begin
         cand_coef = a_ext;
         cand_exp  = ta.exponent;
         adv_i     = 1'b1;
         adv_j     = 1'b0;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_step = cmd.step && cand_keep && pend_valid_ff;

   assign sts.has_work     = a_av || b_av;
   assign sts.step_blocked = cand_keep && pend_valid_ff && !out_free;
   assign sts.out_free     = out_free;

   always_comb begin
      subtract_in   = csr_wr_en ? csr_wr_data : subtract_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      dropped_in    = dropped_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_exp_in   = pend_exp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load_a) begin
         if (wr_a) begin
            cnt_a_in = cnt_a_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.load_b) begin
         if (wr_b) begin
            cnt_b_in = cnt_b_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (cmd.run_start) begin
         i_in          = '0;
         j_in          = '0;
         n_in          = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.step) begin
         if (adv_i) begin
            i_in = i_ff + CW'(1);
         end
         if (adv_j) begin
            j_in = j_ff + CW'(1);
         end
         if (cand_keep) begin
            pend_valid_in = 1'b1;
            pend_coef_in  = cand_coef;
            pend_exp_in   = cand_exp;
            n_in          = n_ff + NW'(1);
         end
      end

      if (emit_step) begin
         rsp_valid_in                   = 1'b1;
         rsp_data_in.result_coefficient = pend_coef_ff;
         rsp_data_in.result_exponent    = pend_exp_ff;
         rsp_data_in.empty_res          = 1'b0;
         rsp_data_in.overflowed         = dropped_ff;
         rsp_data_in.term_count         = '0;
         rsp_data_in.last               = 1'b0;
      end

      if (cmd.finish) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.overflowed = dropped_ff;
         rsp_data_in.last       = 1'b1;
         if (pend_valid_ff) begin
            rsp_data_in.result_coefficient = pend_coef_ff;
            rsp_data_in.result_exponent    = pend_exp_ff;
            rsp_data_in.empty_res          = 1'b0;
            rsp_data_in.term_count         = spa_pkg::TERM_COUNT_WIDTH'(n_ff);
         end else begin
            rsp_data_in.result_coefficient = '0;
            rsp_data_in.result_exponent    = '0;
            rsp_data_in.empty_res          = 1'b1;
            rsp_data_in.term_count         = '0;
         end
         cnt_a_in      = '0;
         cnt_b_in      = '0;
         dropped_in    = 1'b0;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         subtract_ff   <= 1'b0;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         dropped_ff    <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         subtract_ff   <= subtract_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         dropped_ff    <= dropped_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_coef_ff <= pend_coef_in;
      pend_exp_ff  <= pend_exp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/spa_controller.sv -----
// Controller: sequences loads and the merge run of the add/sub unit.
module spa_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_kind,
   output logic             req_stall,
   input  spa_pkg::sts_type sts,
   output spa_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_FETCH   = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;
   localparam logic [1:0] ST_FINISH  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.load_a    = 1'b0;
      cmd.load_b    = 1'b0;
      cmd.run_start = 1'b0;
      cmd.step      = 1'b0;
      cmd.finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_a = (req_kind == spa_pkg::KIND_LOAD_A);
               cmd.load_b = (req_kind == spa_pkg::KIND_LOAD_B);
               if (req_kind == spa_pkg::KIND_RUN) begin
                  cmd.run_start = 1'b1;
                  state_in      = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = sts.has_work ? ST_COMPARE : ST_FINISH;
         end
         ST_COMPARE: begin
            if (!sts.step_blocked) begin
               cmd.step = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- tb/polynomial_merge_checker.sv -----
// Checker: watches the request, result and csr ports, predicts merged terms and compares beats.
module polynomial_merge_checker #(
   parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  spa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  spa_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   output int               failures,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import spa_pkg::*;

   logic signed [31:0] a_coef [MAX_TERMS];
   logic [15:0]        a_expo [MAX_TERMS];
   logic signed [31:0] b_coef [MAX_TERMS];
   logic [15:0]        b_expo [MAX_TERMS];
   int                 a_count = 0;
   int                 b_count = 0;
   bit                 dropped = 1'b0;
   bit                 subtract = 1'b0;
   rsp_type            expected_terms[$];

   initial begin
      failures = 0;
      pending = 0;
   end

   task automatic merge_operands();
      longint      res_coef [2*MAX_TERMS];
      logic [15:0] res_expo [2*MAX_TERMS];
      int          i;
      int          j;
      int          n;
      longint      ta;
      longint      tb;
      longint      s;
      rsp_type     beat;
      i = 0;
      j = 0;
      n = 0;
      while (i < a_count && j < b_count) begin
         ta = a_coef[i];
         tb = b_coef[j];
         if (a_expo[i] == b_expo[j]) begin
            s = subtract ? ta - tb : ta + tb;
            if (s != 0) begin
               res_coef[n] = s;
               res_expo[n] = a_expo[i];
               n++;
            end
            i++;
            j++;
         end else if (a_expo[i] > b_expo[j]) begin
            res_coef[n] = ta;
            res_expo[n] = a_expo[i];
            n++;
            i++;
         end else begin
            res_coef[n] = subtract ? -tb : tb;
            res_expo[n] = b_expo[j];
            n++;
            j++;
         end
      end
      while (i < a_count) begin
         res_coef[n] = a_coef[i];
         res_expo[n] = a_expo[i];
         n++;
         i++;
      end
      while (j < b_count) begin
         tb = b_coef[j];
         res_coef[n] = subtract ? -tb : tb;
         res_expo[n] = b_expo[j];
         n++;
         j++;
      end
      if (n == 0) begin
         beat = '0;
         beat.empty_res = 1'b1;
         beat.overflowed = dropped;
         beat.last = 1'b1;
         expected_terms.push_back(beat);
      end else begin
         for (int k = 0; k < n; k++) begin
            s = res_coef[k];
            beat = '0;
            beat.result_coefficient = s[32:0];
            beat.result_exponent = res_expo[k];
            beat.overflowed = dropped;
            if (k == n - 1) begin
               beat.term_count = TERM_COUNT_WIDTH'(n);
               beat.last = 1'b1;
            end
            expected_terms.push_back(beat);
         end
      end
      a_count = 0;
      b_count = 0;
      dropped = 1'b0;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         a_count = 0;
         b_count = 0;
         dropped = 1'b0;
         subtract = 1'b0;
         expected_terms.delete();
      end else begin
         if (csr_wr_en) begin
            subtract = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            case (req_data.kind)
               KIND_LOAD_A: begin
                  if (a_count < MAX_TERMS) begin
                     a_coef[a_count] = req_data.coefficient;
                     a_expo[a_count] = req_data.exponent;
                     a_count++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               KIND_LOAD_B: begin
                  if (b_count < MAX_TERMS) begin
                     b_coef[b_count] = req_data.coefficient;
                     b_expo[b_count] = req_data.exponent;
                     b_count++;
                  end else begin
                     dropped = 1'b1;
                  end
               end
               KIND_RUN: begin
                  merge_operands();
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_terms.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: unexpected result beat: coef %0d exp %0d empty %0b ovf %0b count %0d last %0b",
                     $time, rsp_data.result_coefficient, rsp_data.result_exponent,
                     rsp_data.empty_res, rsp_data.overflowed, rsp_data.term_count,
                     rsp_data.last);
               end
            end else begin
               want = expected_terms.pop_front();
               if (rsp_data.result_coefficient !== want.result_coefficient ||
                   rsp_data.result_exponent !== want.result_exponent ||
                   rsp_data.empty_res !== want.empty_res ||
                   rsp_data.overflowed !== want.overflowed ||
                   rsp_data.term_count !== want.term_count ||
                   rsp_data.last !== want.last) begin
                  failures++;
                  if (failures <= 10) begin
                     $display("%0t: term differs: expected coef %0d exp %0d empty %0b ovf %0b count %0d last %0b",
                        $time, want.result_coefficient, want.result_exponent, want.empty_res,
                        want.overflowed, want.term_count, want.last);
                     $display("%0t:                  got coef %0d exp %0d empty %0b ovf %0b count %0d last %0b",
                        $time, rsp_data.result_coefficient, rsp_data.result_exponent,
                        rsp_data.empty_res, rsp_data.overflowed, rsp_data.term_count,
                        rsp_data.last);
                  end
               end
            end
         end
      end
      pending = expected_terms.size();
   end

endmodule

// ----- tb/testbench.sv -----
// Testbench top: clock, reset, request and csr stimulus, result stalls and the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spa_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int ITEM_TARGET   = 170;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;
   int      failures;
   int      pending;

   int             cycle_count = 0;
   int             items_sent = 0;
   int             burst_left = 0;
   bit             gaps_on = 1'b1;
   bit             mode_now = 1'b0;
   int             hold_seq = 0;
   int             hold_seen = 0;
   int             hold_left = 0;
   int             window_left = 0;
   int             phase_count = 0;
   stall_mode_type stall_mode = STALL_NONE;

   sparse_polynomial_add_sub_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   polynomial_merge_checker merge_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .pending     (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sparse_polynomial_add_sub_unit: mismatch");
         $finish;
      end
   end

   // result side: random stall pattern, plus a long hold on request
   always @(negedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (window_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         window_left = $urandom_range(20, 80);
      end else begin
         window_left--;
      end
      phase_count++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (phase_count % 7 < 3);
         endcase
      end
   end

   task automatic offer_beat(input logic [1:0] kind, input logic signed [31:0] coef,
                             input logic [15:0] expo);
      req_type beat;
      int      gap;
      beat.kind = kind;
      beat.coefficient = coef;
      beat.exponent = expo;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      if (kind != KIND_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input bit value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mode_now = value;
   endtask

   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'h80000000;
         2:       return 32'sh0;
         3:       return $urandom_range(0, 1) ? 32'sh1 : 32'hffffffff;
         4, 5:    return $urandom_range(0, 200) - 100;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 16) begin
         return $urandom_range(0, 6);
      end else if (r < 19) begin
         return $urandom_range(7, 20);
      end
      return $urandom_range(30, 34);
   endfunction

   // walk a descending exponent ladder (random exponents when unordered); each rung goes to A, B or both
   task automatic send_pair(input int na, input int nb, input bit unordered);
      int                 la;
      int                 lb;
      int                 cur;
      int                 step;
      bit                 take_a;
      bit                 take_b;
      logic signed [31:0] ca;
      logic signed [31:0] cb;
      logic [15:0]        ea;
      logic [15:0]        eb;
      la = 0;
      lb = 0;
      case ($urandom_range(0, 2))
         0:       cur = 65535;
         1:       cur = $urandom_range(0, 65535);
         default: cur = $urandom_range(0, 150);
      endcase
      while (la < na || lb < nb) begin
         take_a = (la < na) && ($urandom_range(0, 2) != 0);
         take_b = (lb < nb) && ($urandom_range(0, 2) != 0);
         if (!take_a && !take_b) begin
            if (la < na) begin
               take_a = 1'b1;
            end else begin
               take_b = 1'b1;
            end
         end
         ea = 16'(unordered ? $urandom_range(0, 65535) : cur);
         eb = 16'(unordered ? $urandom_range(0, 65535) : cur);
         ca = pick_coef();
         if (take_a) begin
            offer_beat(KIND_LOAD_A, ca, ea);
            la++;
         end
         if (take_b) begin
            if (take_a && $urandom_range(0, 2) == 0) begin
               cb = mode_now ? ca : -ca;
            end else begin
               cb = pick_coef();
            end
            offer_beat(KIND_LOAD_B, cb, eb);
            lb++;
         end
         if ($urandom_range(0, 19) == 0) begin
            offer_beat(KIND_UNUSED, $urandom, 16'($urandom));
         end
         step = 1 + $urandom_range(0, cur / 70);
         cur = (cur > step) ? cur - step : 0;
      end
      offer_beat(KIND_RUN, $urandom, 16'($urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      offer_beat(KIND_RUN, 32'sh0, 16'h0);
      offer_beat(KIND_LOAD_A, 32'sh7fffffff, 16'hffff);
      offer_beat(KIND_LOAD_A, 32'h80000000, 16'd300);
      offer_beat(KIND_LOAD_A, 32'sh0, 16'd5);
      offer_beat(KIND_LOAD_B, 32'sh7fffffff, 16'hffff);
      offer_beat(KIND_LOAD_B, 32'sh1, 16'd300);
      offer_beat(KIND_LOAD_B, 32'hffffffff, 16'd0);
      offer_beat(KIND_UNUSED, 32'hffffffff, 16'hffff);
      offer_beat(KIND_RUN, 32'hffffffff, 16'hffff);
      offer_beat(KIND_LOAD_A, 32'sd5, 16'd10);
      offer_beat(KIND_LOAD_B, -32'sd5, 16'd10);
      offer_beat(KIND_RUN, 32'sh0, 16'h0);

      wait_idle();
      write_mode(1'b1);
      offer_beat(KIND_LOAD_A, 32'sd3, 16'd9);
      offer_beat(KIND_LOAD_A, 32'h80000000, 16'd2);
      offer_beat(KIND_LOAD_B, 32'sd3, 16'd9);
      offer_beat(KIND_LOAD_B, 32'sh7fffffff, 16'd2);
      offer_beat(KIND_LOAD_B, 32'h80000000, 16'd1);
      offer_beat(KIND_LOAD_B, 32'sd7, 16'd0);
      offer_beat(KIND_RUN, 32'sh0, 16'h0);
      offer_beat(KIND_LOAD_A, 32'sd1, 16'd1);
      offer_beat(KIND_LOAD_A, 32'sd1, 16'd50);
      offer_beat(KIND_LOAD_B, 32'sd2, 16'd50);
      offer_beat(KIND_RUN, 32'sh0, 16'h0);

      // overfill store A, and often store B too
      send_pair($urandom_range(33, 34), $urandom_range(28, 34), 1'b0);

      // hold the result side while loads keep coming, then drain fully
      wait_idle();
      @(posedge clock);
      hold_seq++;
      gaps_on = 1'b0;
      send_pair(5, 5, 1'b0);
      send_pair(4, 3, 1'b0);
      wait_idle();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_mode(1'($urandom_range(0, 1)));
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         send_pair(pick_count(), pick_count(), $urandom_range(0, 9) == 0);
      end

      wait_idle();
      if (failures == 0 && pending == 0) begin
         $display("sparse_polynomial_add_sub_unit: match");
      end else begin
         $display("sparse_polynomial_add_sub_unit: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/spa_pkg.sv
rtl/spa_ram.sv
rtl/spa_datapath.sv
rtl/spa_controller.sv
rtl/sparse_polynomial_add_sub_unit.sv
tb/polynomial_merge_checker.sv
tb/testbench.sv
